// ----- hw/rtl/kac_pkg.sv -----
// Shared types and constants of the keypad alarm controller.
`default_nettype none
package kac_pkg;

    // Keypad keys with a special meaning.
    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_HOLD  = 8'h23;
    localparam logic [7:0] KEY_STOP  = 8'h2A;
    localparam logic [7:0] KEY_CHECK = 8'h44;

    localparam logic [7:0] HOLD_DEFAULT = 8'd20;

    // Reported mode codes.
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_DISARMED = 3'd1;
    localparam logic [2:0] MODE_ARMED    = 3'd2;
    localparam logic [2:0] MODE_ALARM    = 3'd3;
    localparam logic [2:0] MODE_STOPPED  = 3'd4;

    // Reported event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ARMED    = 3'd1;
    localparam logic [2:0] EV_ARM_FAIL = 3'd2;
    localparam logic [2:0] EV_DISARMED = 3'd3;
    localparam logic [2:0] EV_WRONG    = 3'd4;
    localparam logic [2:0] EV_STOPPED  = 3'd5;

    // Register indexes; each register sits at byte address 8 * index.
    localparam logic [2:0] REG_HOLD_TICKS = 3'd0;
    localparam logic [2:0] REG_PASSCODE_A = 3'd1;
    localparam logic [2:0] REG_PASSCODE_B = 3'd2;
    localparam logic [2:0] REG_PASSCODE_C = 3'd3;
    localparam logic [2:0] REG_PASSCODE_D = 3'd4;

    localparam int NUM_SLOTS  = 4;
    localparam int PC_LEN_LSB = 56;
    localparam int PADDR_W    = 6;

    typedef struct packed {
        logic [7:0] key_code;
        logic       door_open;
    } t_in_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] event_res;
        logic [2:0] entry_length;
    } t_out_item;

    typedef struct packed {
        logic [7:0]                      hold_ticks;
        logic [NUM_SLOTS-1:0][63:0]      passcode;
    } t_cfg;

endpackage
`default_nettype wire

// ----- hw/rtl/kac_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none
module kac_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kac_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    output kac_pkg::t_cfg                    o_cfg
);

    kac_pkg::t_cfg r_cfg;
    logic [2:0]    addr_idx;
    logic          wr_en;

    assign addr_idx = paddr[5:3];
    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks <= kac_pkg::HOLD_DEFAULT;
            r_cfg.passcode   <= '0;
        end else if (wr_en) begin
            unique case (addr_idx)
                kac_pkg::REG_HOLD_TICKS: r_cfg.hold_ticks  <= pwdata[7:0];
                kac_pkg::REG_PASSCODE_A: r_cfg.passcode[0] <= pwdata;
                kac_pkg::REG_PASSCODE_B: r_cfg.passcode[1] <= pwdata;
                kac_pkg::REG_PASSCODE_C: r_cfg.passcode[2] <= pwdata;
                kac_pkg::REG_PASSCODE_D: r_cfg.passcode[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr_idx)
            kac_pkg::REG_HOLD_TICKS: prdata = {56'd0, r_cfg.hold_ticks};
            kac_pkg::REG_PASSCODE_A: prdata = r_cfg.passcode[0];
            kac_pkg::REG_PASSCODE_B: prdata = r_cfg.passcode[1];
            kac_pkg::REG_PASSCODE_C: prdata = r_cfg.passcode[2];
            kac_pkg::REG_PASSCODE_D: prdata = r_cfg.passcode[3];
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hw/rtl/kac_match.sv -----
// Parallel compare of the entered code against the four passcode slots.
`default_nettype none
module kac_match #(
    parameter int MAX_CODE_CHARS = 7
) (
    input  wire logic [kac_pkg::NUM_SLOTS-1:0][63:0] i_passcode,
    input  wire logic [MAX_CODE_CHARS-1:0][7:0]      i_chars,
    input  wire logic [2:0]                          i_count,
    output logic                                     o_hit
);

    logic [kac_pkg::NUM_SLOTS-1:0] slot_ok;

    always_comb begin
        logic [3:0] len;
        for (int s = 0; s < kac_pkg::NUM_SLOTS; s++) begin
            len = i_passcode[s][kac_pkg::PC_LEN_LSB +: 4];
            // A slot of length zero is disabled; one longer than the buffer never matches.
            slot_ok[s] = (len != 4'd0) && (len <= 4'(MAX_CODE_CHARS))
                         && (len == {1'b0, i_count});
            for (int k = 0; k < MAX_CODE_CHARS; k++) begin
                if ((4'(k) < len) && (i_passcode[s][8*k +: 8] != i_chars[k])) begin
                    slot_ok[s] = 1'b0;
                end
            end
        end
    end

    assign o_hit = |slot_ok;

endmodule
`default_nettype wire

// ----- hw/rtl/keypad_alarm_controller_unit.sv -----
// Top level of the keypad alarm controller: input stage, mode FSM and result register.
//
//  channel  direction  payload              handshake
//  in       input      i_in_data (t_in_item)   i_in_valid / o_in_stall
//  out      output     o_out_data (t_out_item) o_out_valid / i_out_stall
//  cfg      input      paddr, pwdata, prdata   psel, penable, pwrite, pready
//
// A keypad poll is captured in the input register, and the FSM step then writes its result
// into the result register, from which the transaction leaves.
// One poll is accepted every cycle while the result side does not stall; the single FSM step sets that rate.
// Reset puts the block in start mode with an empty code buffer and restores defaults.
// A stall on the result side holds the result register and, while a poll waits in the input
// register, holds that register too and raises o_in_stall in the same cycle.
`default_nettype none
module keypad_alarm_controller_unit #(
    parameter int MAX_CODE_CHARS = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire kac_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output kac_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kac_pkg::PADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [4:0] {
        ST_START    = 5'b00001,
        ST_DISARMED = 5'b00010,
        ST_ARMED    = 5'b00100,
        ST_ALARM    = 5'b01000,
        ST_STOPPED  = 5'b10000
    } t_state;

    kac_pkg::t_cfg      cfg;
    logic               hit;

    logic               r_in_valid;
    kac_pkg::t_in_item  r_in;
    logic               r_out_valid;
    kac_pkg::t_out_item r_out;
    logic               advance;

    t_state                     r_state, n_state;
    logic [7:0]                 r_hold, n_hold;
    logic                       r_latch, n_latch;
    logic [MAX_CODE_CHARS-1:0][7:0] r_chars, n_chars;
    logic [2:0]                 r_count, n_count;
    logic [2:0]                 ev;
    logic [2:0]                 mode_code;

    kac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kac_match #(
        .MAX_CODE_CHARS (MAX_CODE_CHARS)
    ) u_match (
        .i_passcode (cfg.passcode),
        .i_chars    (r_chars),
        .i_count    (r_count),
        .o_hit      (hit)
    );

    // The FSM step fires when a poll waits and the result register is empty or not stalled.
    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        logic [7:0] hold_inc;
        logic       clear_entry;
        n_state     = r_state;
        n_hold      = r_hold;
        n_latch     = r_latch;
        n_chars     = r_chars;
        n_count     = r_count;
        ev          = kac_pkg::EV_NONE;
        clear_entry = 1'b0;
        hold_inc    = r_hold + 8'd1;

        unique case (r_state)
            ST_START: begin
                n_state = ST_DISARMED;
            end
            ST_DISARMED: begin
                if (r_in.key_code != kac_pkg::KEY_NONE) begin
                    if (r_in.key_code == kac_pkg::KEY_STOP) begin
                        n_state = ST_STOPPED;
                        ev      = kac_pkg::EV_STOPPED;
                    end
                    if (r_in.key_code == kac_pkg::KEY_HOLD) begin
                        n_hold = hold_inc;
                        if (hold_inc == cfg.hold_ticks) begin
                            clear_entry = 1'b1;
                            n_hold      = 8'd0;
                            n_latch     = 1'b1;
                            if (!r_in.door_open) begin
                                n_state = ST_ARMED;
                                ev      = kac_pkg::EV_ARMED;
                            end else begin
                                ev = kac_pkg::EV_ARM_FAIL;
                            end
                        end
                    end else begin
                        n_hold = 8'd0;
                    end
                end
            end
            ST_ARMED, ST_ALARM: begin
                if (r_in.key_code != kac_pkg::KEY_NONE) begin
                    if (!r_latch) begin
                        n_latch = 1'b1;
                        if (r_in.key_code == kac_pkg::KEY_CHECK) begin
                            n_state     = hit ? ST_DISARMED : ST_ALARM;
                            ev          = hit ? kac_pkg::EV_DISARMED : kac_pkg::EV_WRONG;
                            clear_entry = 1'b1;
                        end else if (r_count < 3'(MAX_CODE_CHARS)) begin
                            for (int k = 0; k < MAX_CODE_CHARS; k++) begin
                                if (r_count == 3'(k)) begin
                                    n_chars[k] = r_in.key_code;
                                end
                            end
                            n_count = r_count + 3'd1;
                        end
                    end
                    // A star stops the block even after it was buffered.
                    if (r_in.key_code == kac_pkg::KEY_STOP) begin
                        n_state = ST_STOPPED;
                        ev      = kac_pkg::EV_STOPPED;
                    end
                end else begin
                    n_latch = 1'b0;
                end
            end
            ST_STOPPED: begin
                n_state = ST_STOPPED;
            end
            default: begin
                n_state = ST_STOPPED;
            end
        endcase

        if (clear_entry) begin
            n_chars = '0;
            n_count = 3'd0;
        end
    end

    always_comb begin
        unique case (n_state)
            ST_START:    mode_code = kac_pkg::MODE_START;
            ST_DISARMED: mode_code = kac_pkg::MODE_DISARMED;
            ST_ARMED:    mode_code = kac_pkg::MODE_ARMED;
            ST_ALARM:    mode_code = kac_pkg::MODE_ALARM;
            ST_STOPPED:  mode_code = kac_pkg::MODE_STOPPED;
            default:     mode_code = kac_pkg::MODE_STOPPED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_hold  <= 8'd0;
            r_latch <= 1'b0;
            r_chars <= '0;
            r_count <= 3'd0;
        end else if (advance) begin
            r_state <= n_state;
            r_hold  <= n_hold;
            r_latch <= n_latch;
            r_chars <= n_chars;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.mode         <= mode_code;
            r_out.event_res    <= ev;
            r_out.entry_length <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(MAX_CODE_CHARS))
        else $error("code buffer count exceeds capacity");

    a_stop_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STOPPED |=> r_state == ST_STOPPED)
        else $error("block left the stopped mode");

    a_disarmed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DISARMED |-> r_count == 3'd0)
        else $error("code buffer not empty while disarmed");

    a_len_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) && $past(i_rst_n) |-> r_out.entry_length == r_count)
        else $error("reported entry length differs from buffer count");
`endif

endmodule
`default_nettype wire
